@@ design/nteu_pkg.sv @@
// ---------------------------------------------------------------------------
// nteu_pkg
// Shared sizes, lookup table, microcode words and program for the n-tuple
// value evaluate and update core.
// ---------------------------------------------------------------------------
package nteu_pkg;

  localparam int VERTICAL_TABLES   = 1;
  localparam int HORIZONTAL_TABLES = 1;
  localparam int BOARD_SIDE        = 4;
  localparam int TILE_LEVELS       = 16;

  localparam int NUM_ACTIONS   = 4;
  localparam int SQUARE_TABLES = (BOARD_SIDE - 1) * (BOARD_SIDE - 1);
  localparam int TBL_PER_ACT   = VERTICAL_TABLES + HORIZONTAL_TABLES + SQUARE_TABLES;
  localparam int LUT_SIZE      = TILE_LEVELS * TILE_LEVELS * TILE_LEVELS * TILE_LEVELS;
  localparam int STORE_DEPTH   = NUM_ACTIONS * TBL_PER_ACT * LUT_SIZE;
  localparam int N_LK          = (VERTICAL_TABLES + HORIZONTAL_TABLES) * BOARD_SIDE
                                 + SQUARE_TABLES;

  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int K_W      = $clog2(N_LK);
  localparam int TBL_W    = $clog2(TBL_PER_ACT);
  localparam int TILE_W   = 4;
  localparam int POS_W    = 4;
  localparam int WEIGHT_W = 32;
  localparam int SUM_W    = 38;
  localparam int BOARD_W  = 64;
  localparam int ACTION_W = 2;

  localparam int IN_TDATA_W  = BOARD_W + WEIGHT_W;
  localparam int IN_TUSER_W  = 1 + ACTION_W;
  localparam int OUT_TDATA_W = ((SUM_W + 7) / 8) * 8;

  localparam logic CMD_EVAL   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  // one lookup: table within the action set, four tile positions, msd first
  typedef struct packed {
    logic [TBL_W-1:0]            tbl;
    logic [3:0][POS_W-1:0]       pos;
  } lk_t;

  typedef lk_t [N_LK-1:0] lk_tab_t;

  function automatic logic [POS_W-1:0] pos_of(input int r, input int c);
    return POS_W'(r * BOARD_SIDE + c);
  endfunction

  function automatic lk_tab_t lk_build();
    lk_tab_t t;
    int      n;
    t = '0;
    n = 0;
    for (int k = 0; k < VERTICAL_TABLES; k++) begin
      for (int j = 0; j < BOARD_SIDE; j++) begin
        t[n].tbl    = TBL_W'(k);
        t[n].pos[0] = pos_of(0, j);
        t[n].pos[1] = pos_of(1, j);
        t[n].pos[2] = pos_of(2, j);
        t[n].pos[3] = pos_of(3, j);
        n++;
      end
    end
    for (int k = 0; k < HORIZONTAL_TABLES; k++) begin
      for (int i = 0; i < BOARD_SIDE; i++) begin
        t[n].tbl    = TBL_W'(VERTICAL_TABLES + k);
        t[n].pos[0] = pos_of(i, 0);
        t[n].pos[1] = pos_of(i, 1);
        t[n].pos[2] = pos_of(i, 2);
        t[n].pos[3] = pos_of(i, 3);
        n++;
      end
    end
    for (int i = 0; i < BOARD_SIDE - 1; i++) begin
      for (int j = 0; j < BOARD_SIDE - 1; j++) begin
        t[n].tbl    = TBL_W'(VERTICAL_TABLES + HORIZONTAL_TABLES + i * (BOARD_SIDE - 1) + j);
        t[n].pos[0] = pos_of(i, j);
        t[n].pos[1] = pos_of(i, j + 1);
        t[n].pos[2] = pos_of(i + 1, j);
        t[n].pos[3] = pos_of(i + 1, j + 1);
        n++;
      end
    end
    return t;
  endfunction

  localparam lk_tab_t LK_TAB = lk_build();

  // microcode
  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_RD_SUM,
    MEM_RD,
    MEM_WR_UPD,
    MEM_WR_ZERO
  } mem_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_K_ZERO,
    CNT_K_INC,
    CNT_CLR_INC
  } cnt_op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_BEAT,
    C_K_LAST,
    C_CLR_LAST,
    C_IS_EVAL,
    C_OUT_FREE
  } cond_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SUM,
    S_DRAIN,
    S_URD,
    S_UWR,
    S_OUT
  } step_t;

  typedef struct packed {
    mem_op_t mem;
    cnt_op_t cnt;
    cond_t   cond;
    logic    in_rdy;
    logic    out_load;
    step_t   jt;
    step_t   nt;
  } uword_t;

  typedef struct packed {
    logic in_beat;
    logic k_last;
    logic clr_last;
    logic is_eval;
    logic out_free;
  } sts_t;

  function automatic uword_t urom(input step_t pc);
    uword_t w;
    w = '{mem: MEM_NONE, cnt: CNT_HOLD, cond: C_ALWAYS, in_rdy: 1'b0,
          out_load: 1'b0, jt: S_IDLE, nt: S_IDLE};
    unique case (pc)
      S_CLR: begin
        w.mem  = MEM_WR_ZERO;
        w.cnt  = CNT_CLR_INC;
        w.cond = C_CLR_LAST;
        w.jt   = S_IDLE;
        w.nt   = S_CLR;
      end
      S_IDLE: begin
        w.cnt    = CNT_K_ZERO;
        w.cond   = C_IN_BEAT;
        w.in_rdy = 1'b1;
        w.jt     = S_SUM;
        w.nt     = S_IDLE;
      end
      S_SUM: begin
        w.mem  = MEM_RD_SUM;
        w.cnt  = CNT_K_INC;
        w.cond = C_K_LAST;
        w.jt   = S_DRAIN;
        w.nt   = S_SUM;
      end
      S_DRAIN: begin
        w.cond = C_IS_EVAL;
        w.jt   = S_OUT;
        w.nt   = S_URD;
      end
      S_URD: begin
        w.mem  = MEM_RD;
        w.cond = C_ALWAYS;
        w.jt   = S_UWR;
        w.nt   = S_UWR;
      end
      S_UWR: begin
        w.mem  = MEM_WR_UPD;
        w.cnt  = CNT_K_INC;
        w.cond = C_K_LAST;
        w.jt   = S_OUT;
        w.nt   = S_URD;
      end
      S_OUT: begin
        w.cond     = C_OUT_FREE;
        w.out_load = 1'b1;
        w.jt       = S_IDLE;
        w.nt       = S_OUT;
      end
      default: begin
        w.jt = S_IDLE;
        w.nt = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ design/ntuple_value_evaluate_update_core.sv @@
// ---------------------------------------------------------------------------
// ntuple_value_evaluate_update_core
// N-tuple value network on a 4x4 board: evaluate or update one action's
// weights, returning the pre-update sum of the indexed weights.
//
// Input channel (in_*): one beat per command. in_tuser carries the command
// (evaluate or update) and the action; in_tdata the board and the signed
// Q16.16 delta. Output channel (out_*): one beat per command holding the
// signed sum of the seventeen indexed weights read before any update.
// Each lookup is one access of the single-port weight RAM, driven by a
// microcoded sequencer. An evaluate makes one summing pass over the
// lookups; an update adds a read and a write per lookup after that pass.
// After reset the sequencer sweeps the weight RAM writing zeros, one entry
// a cycle, with in_tready low. A stalled output holds its beat in the
// result register; the next command is accepted and worked on meanwhile
// and waits only for that register to empty.
// ---------------------------------------------------------------------------
module ntuple_value_evaluate_update_core import nteu_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // board [63:0], delta [95:64]
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // command [0], action [2:1]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // value_sum [37:0], zero pad [39:38]
);

  uword_t              ctl;
  sts_t                sts;
  logic                ram_en, ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [WEIGHT_W-1:0] ram_wdata, ram_rdata;

  nteu_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  nteu_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .ram_en     (ram_en),
    .ram_we     (ram_we),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata)
  );

  nteu_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (STORE_DEPTH)
  ) u_weights (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

@@ design/nteu_ram.sv @@
// ---------------------------------------------------------------------------
// nteu_ram
// Generic single-port RAM, one read or one write per cycle, registered read.
// ---------------------------------------------------------------------------
module nteu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/nteu_seq.sv @@
// ---------------------------------------------------------------------------
// nteu_seq
// Microcode sequencer: step counter, program rom and conditional jumps.
// ---------------------------------------------------------------------------
module nteu_seq import nteu_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  sts_t   sts,
  output uword_t ctl
);

  step_t pc_r;
  step_t pc_nxt;
  logic  take;

  assign ctl = urom(pc_r);

  always_comb begin
    unique case (ctl.cond)
      C_ALWAYS:   take = 1'b1;
      C_IN_BEAT:  take = sts.in_beat;
      C_K_LAST:   take = sts.k_last;
      C_CLR_LAST: take = sts.clr_last;
      C_IS_EVAL:  take = sts.is_eval;
      C_OUT_FREE: take = sts.out_free;
      default:    take = 1'b0;
    endcase
    pc_nxt = take ? ctl.jt : ctl.nt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_CLR;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> pc_r == S_CLR)
    else $error("sequencer did not restart at the clearing pass");

endmodule

@@ design/nteu_dp.sv @@
// ---------------------------------------------------------------------------
// nteu_dp
// Datapath: beat capture, lookup address generation, weight accumulator,
// saturating update, clear counter and result register.
// ---------------------------------------------------------------------------
module nteu_dp import nteu_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  uword_t                 ctl,
  output sts_t                   sts,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   ram_en,
  output logic                   ram_we,
  output logic [ADDR_W-1:0]      ram_addr,
  output logic [WEIGHT_W-1:0]    ram_wdata,
  input  logic [WEIGHT_W-1:0]    ram_rdata
);

  logic                cmd_r;
  logic [ACTION_W-1:0] action_r;
  logic [BOARD_W-1:0]  board_r;
  logic [WEIGHT_W-1:0] delta_r;
  logic [K_W-1:0]      k_r, k_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic [SUM_W-1:0]    acc_r, acc_nxt;
  logic                acc_en_r;
  logic                out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]    out_data_r;

  logic                in_beat, k_last, clr_last, out_free, out_load;
  lk_t                 lk;
  logic [TILE_W-1:0]   tile [4];
  logic [ADDR_W-1:0]   dig, tbl_full, lk_addr;
  logic [WEIGHT_W:0]   upd_sum;
  logic [WEIGHT_W-1:0] sat_w;
  logic [SUM_W-1:0]    rd_ext;

  assign in_tready = ctl.in_rdy;
  assign in_beat   = in_tvalid & ctl.in_rdy;
  assign k_last    = (k_r == K_W'(N_LK - 1));
  assign clr_last  = (clr_r == ADDR_W'(STORE_DEPTH - 1));
  assign out_free  = !out_valid_r || out_tready;
  assign out_load  = ctl.out_load && out_free;

  assign sts = '{in_beat: in_beat, k_last: k_last, clr_last: clr_last,
                 is_eval: (cmd_r == CMD_EVAL), out_free: out_free};

  // lookup address: table base plus four tile digits, top/left digit first
  always_comb begin
    lk  = LK_TAB[k_r];
    dig = '0;
    for (int i = 0; i < 4; i++) begin
      tile[i] = board_r[{lk.pos[i], 2'b00} +: TILE_W];
      if (5'(tile[i]) >= 5'(TILE_LEVELS)) begin
        tile[i] = TILE_W'(TILE_LEVELS - 1);
      end
      dig = dig * ADDR_W'(TILE_LEVELS) + ADDR_W'(tile[i]);
    end
    tbl_full = ADDR_W'(action_r) * ADDR_W'(TBL_PER_ACT) + ADDR_W'(lk.tbl);
    lk_addr  = tbl_full * ADDR_W'(LUT_SIZE) + dig;
  end

  // saturating weight update
  always_comb begin
    upd_sum = {ram_rdata[WEIGHT_W-1], ram_rdata} + {delta_r[WEIGHT_W-1], delta_r};
    if (upd_sum[WEIGHT_W] != upd_sum[WEIGHT_W-1]) begin
      sat_w = upd_sum[WEIGHT_W] ? W_MIN : W_MAX;
    end else begin
      sat_w = upd_sum[WEIGHT_W-1:0];
    end
  end

  assign ram_en    = (ctl.mem != MEM_NONE);
  assign ram_we    = (ctl.mem == MEM_WR_UPD) || (ctl.mem == MEM_WR_ZERO);
  assign ram_addr  = (ctl.mem == MEM_WR_ZERO) ? clr_r : lk_addr;
  assign ram_wdata = (ctl.mem == MEM_WR_ZERO) ? '0 : sat_w;

  assign rd_ext = {{(SUM_W - WEIGHT_W){ram_rdata[WEIGHT_W-1]}}, ram_rdata};

  always_comb begin
    k_nxt   = k_r;
    clr_nxt = clr_r;
    case (ctl.cnt)
      CNT_K_ZERO:  k_nxt = '0;
      CNT_K_INC:   k_nxt = k_last ? '0 : k_r + K_W'(1);
      CNT_CLR_INC: clr_nxt = clr_last ? clr_r : clr_r + ADDR_W'(1);
      default:     k_nxt = k_r;
    endcase

    acc_nxt = acc_r;
    if (in_beat) begin
      acc_nxt = '0;
    end else if (acc_en_r) begin
      acc_nxt = acc_r + rd_ext;
    end

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      clr_r       <= '0;
      acc_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      clr_r       <= clr_nxt;
      acc_en_r    <= (ctl.mem == MEM_RD_SUM);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (in_beat) begin
      cmd_r    <= in_tuser[0];
      action_r <= in_tuser[ACTION_W:1];
      board_r  <= in_tdata[BOARD_W-1:0];
      delta_r  <= in_tdata[IN_TDATA_W-1:BOARD_W];
    end
    if (out_load) begin
      out_data_r <= acc_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

  a_upd_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.mem == MEM_WR_UPD |-> $past(ctl.mem) == MEM_RD && $stable(ram_addr))
    else $error("weight write-back address differs from its read");

  a_sum_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> k_r == '0 && acc_r == '0 && !acc_en_r)
    else $error("lookup pass did not start clean");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid && out_data_r == $past(acc_r))
    else $error("result register missed the sum");

endmodule

@@ dv/ntuple_value_evaluate_update_core_test.sv @@
// ---------------------------------------------------------------------------
// ntuple_value_evaluate_update_core_test
// Self-checking bench for the n-tuple evaluate and update core. It waits out
// the weight clear after reset and then drives a short table of commands:
// all-zero and all-max boards, every action, saturating deltas and deltas
// on evaluates. A random mix of evaluates and updates follows, half of it
// drawn from a small set of recurring boards, so that weights build up and
// saturate. Each returned sum is checked against the table's value or a
// sparse model of the weight store in the bench. Both channels idle at random.
// One long output stall fills the core, and one pause waits for it to drain.
// ---------------------------------------------------------------------------
module ntuple_value_evaluate_update_core_test import nteu_pkg::*;;

  localparam int RAND_ITEMS = 1130;
  localparam int DIR_N      = 20;
  localparam int POOL_N     = 16;

  typedef struct packed {
    logic                cmd;
    logic [ACTION_W-1:0] act;
    logic [BOARD_W-1:0]  board;
    logic [WEIGHT_W-1:0] delta;
    logic                typed;
    logic [SUM_W-1:0]    want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [DIR_N] = '{
    '{CMD_EVAL,   2'd0, 64'h0,                 32'h0000_0000, 1'b1, 38'h0},
    '{CMD_EVAL,   2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 1'b1, 38'h0},
    '{CMD_UPDATE, 2'd0, 64'h0,                 32'h7FFF_FFFF, 1'b1, 38'h0},
    '{CMD_UPDATE, 2'd0, 64'h0,                 32'h7FFF_FFFF, 1'b0, 38'h0},
    '{CMD_EVAL,   2'd0, 64'h0,                 32'h1234_5678, 1'b0, 38'h0},
    '{CMD_EVAL,   2'd1, 64'h0,                 32'h0000_0000, 1'b1, 38'h0},
    '{CMD_UPDATE, 2'd1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 1'b1, 38'h0},
    '{CMD_UPDATE, 2'd1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 1'b0, 38'h0},
    '{CMD_EVAL,   2'd1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 38'h0},
    '{CMD_UPDATE, 2'd0, 64'h0,                 32'h8000_0000, 1'b0, 38'h0},
    '{CMD_EVAL,   2'd0, 64'h0,                 32'hFFFF_FFFF, 1'b0, 38'h0},
    '{CMD_UPDATE, 2'd2, 64'h0123_4567_89AB_CDEF, 32'h0000_0001, 1'b1, 38'h0},
    '{CMD_EVAL,   2'd2, 64'h0123_4567_89AB_CDEF, 32'h0000_0000, 1'b0, 38'h0},
    '{CMD_UPDATE, 2'd2, 64'hFEDC_BA98_7654_3210, 32'hFFFF_FFFF, 1'b0, 38'h0},
    '{CMD_UPDATE, 2'd3, 64'h5555_5555_5555_5555, 32'h0000_0000, 1'b1, 38'h0},
    '{CMD_EVAL,   2'd3, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0000_0000, 1'b0, 38'h0},
    '{CMD_UPDATE, 2'd2, 64'h0123_4567_89AB_CDEF, 32'h0001_0000, 1'b0, 38'h0},
    '{CMD_EVAL,   2'd2, 64'hFEDC_BA98_7654_3210, 32'h0000_0000, 1'b0, 38'h0},
    '{CMD_UPDATE, 2'd0, 64'hF0F0_F0F0_F0F0_F0F0, 32'hFFFF_0000, 1'b0, 38'h0},
    '{CMD_EVAL,   2'd0, 64'hF0F0_F0F0_F0F0_F0F0, 32'h0000_0000, 1'b0, 38'h0}
  };

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // board [63:0], delta [95:64]
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;   // command [0], action [2:1]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // value_sum [37:0], zero pad [39:38]

  logic signed [WEIGHT_W-1:0] weight_mem [int unsigned];
  logic [SUM_W-1:0]           sum_queue [$];
  logic [BOARD_W-1:0]         board_pool [POOL_N];

  int fail_count   = 0;
  int cmds_sent    = 0;
  int updates_sent = 0;
  int sums_checked = 0;
  int sat_writes   = 0;

  ntuple_value_evaluate_update_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic signed [WEIGHT_W-1:0] weight_at(input int unsigned addr);
    return weight_mem.exists(addr) ? weight_mem[addr] : '0;
  endfunction

  function automatic int unsigned entry_addr(input int unsigned act, input int unsigned tbl,
                                             input int unsigned a, input int unsigned b,
                                             input int unsigned c, input int unsigned d);
    return (act * TBL_PER_ACT + tbl) * LUT_SIZE +
           ((a * TILE_LEVELS + b) * TILE_LEVELS + c) * TILE_LEVELS + d;
  endfunction

  // sum of the indexed weights before the command; applies an update
  task automatic tuple_value_apply(input logic cmd, input logic [ACTION_W-1:0] act,
                                   input logic [BOARD_W-1:0] board,
                                   input logic [WEIGHT_W-1:0] delta,
                                   output logic [SUM_W-1:0] sum);
    int unsigned addr [N_LK];
    int unsigned tile [BOARD_SIDE][BOARD_SIDE];
    int          n;
    longint      acc;
    longint      upd;
    n   = 0;
    acc = 0;
    for (int r = 0; r < BOARD_SIDE; r++) begin
      for (int c = 0; c < BOARD_SIDE; c++) begin
        tile[r][c] = board[TILE_W*(r*BOARD_SIDE+c) +: TILE_W];
        if (tile[r][c] >= TILE_LEVELS) tile[r][c] = TILE_LEVELS - 1;
      end
    end
    for (int k = 0; k < VERTICAL_TABLES; k++) begin
      for (int j = 0; j < BOARD_SIDE; j++) begin
        addr[n] = entry_addr(act, k, tile[0][j], tile[1][j], tile[2][j], tile[3][j]);
        n++;
      end
    end
    for (int k = 0; k < HORIZONTAL_TABLES; k++) begin
      for (int i = 0; i < BOARD_SIDE; i++) begin
        addr[n] = entry_addr(act, VERTICAL_TABLES + k,
                             tile[i][0], tile[i][1], tile[i][2], tile[i][3]);
        n++;
      end
    end
    for (int i = 0; i < BOARD_SIDE - 1; i++) begin
      for (int j = 0; j < BOARD_SIDE - 1; j++) begin
        addr[n] = entry_addr(act, VERTICAL_TABLES + HORIZONTAL_TABLES + i*(BOARD_SIDE-1) + j,
                             tile[i][j], tile[i][j+1], tile[i+1][j], tile[i+1][j+1]);
        n++;
      end
    end
    for (int k = 0; k < n; k++) acc += longint'(weight_at(addr[k]));
    if (cmd == CMD_UPDATE) begin
      // repeated entries take the delta once per hit
      for (int k = 0; k < n; k++) begin
        upd = longint'(weight_at(addr[k])) + longint'($signed(delta));
        if (upd > longint'($signed(W_MAX))) begin
          upd = longint'($signed(W_MAX));
          sat_writes++;
        end else if (upd < longint'($signed(W_MIN))) begin
          upd = longint'($signed(W_MIN));
          sat_writes++;
        end
        weight_mem[addr[k]] = upd[WEIGHT_W-1:0];
      end
    end
    sum = acc[SUM_W-1:0];
  endtask

  function automatic int sender_gap(input int item);
    int r;
    r = $urandom_range(0, 9);
    if (item >= 700 && item < 850) return 0;
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  task automatic send_cmd(input logic cmd, input logic [ACTION_W-1:0] act,
                          input logic [BOARD_W-1:0] board,
                          input logic [WEIGHT_W-1:0] delta,
                          input logic typed, input logic [SUM_W-1:0] want, input int item);
    logic [SUM_W-1:0] predicted;
    int               gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {delta, board};
    in_tuser  <= {act, cmd};
    do @(posedge clk); while (!in_tready);
    tuple_value_apply(cmd, act, board, delta, predicted);
    sum_queue.push_back(typed ? want : predicted);
    cmds_sent++;
    if (cmd == CMD_UPDATE) updates_sent++;
    gap = sender_gap(item);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [BOARD_W-1:0] low_tile_board();
    logic [BOARD_W-1:0] b;
    for (int t = 0; t < 16; t++) b[TILE_W*t +: TILE_W] = TILE_W'($urandom_range(0, 3));
    return b;
  endfunction

  // stimulus
  initial begin
    logic                cmd;
    logic [ACTION_W-1:0] act;
    logic [BOARD_W-1:0]  board;
    logic [WEIGHT_W-1:0] delta;
    int                  pick;
    int                  r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      send_cmd(DIRECTED[i].cmd, DIRECTED[i].act, DIRECTED[i].board, DIRECTED[i].delta,
               DIRECTED[i].typed, DIRECTED[i].want, i);
    end

    for (int p = 0; p < POOL_N; p++) board_pool[p] = low_tile_board();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 500) begin
        in_tvalid <= 1'b0;
        while (sum_queue.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, POOL_N - 1);
      if ($urandom_range(0, 19) == 0) board_pool[pick] = low_tile_board();
      r = $urandom_range(0, 9);
      if (r < 5) begin
        board = board_pool[pick];
        if (r == 0) board[TILE_W*$urandom_range(0, 15) +: TILE_W] = TILE_W'($urandom);
      end else if (r < 7) begin
        board = low_tile_board();
      end else begin
        board = {$urandom, $urandom};
      end
      r = $urandom_range(0, 9);
      if (r == 0) delta = $urandom_range(0, 1) ? W_MAX : W_MIN;
      else if (r < 3) delta = $urandom;
      else delta = WEIGHT_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      cmd = ($urandom_range(0, 9) < 4) ? CMD_UPDATE : CMD_EVAL;
      act = ACTION_W'($urandom_range(0, NUM_ACTIONS - 1));
      send_cmd(cmd, act, board, delta, 1'b0, '0, DIR_N + i);
    end
    in_tvalid <= 1'b0;

    while (sum_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("%0d commands (%0d updates) over four action sets, %0d sums checked",
             cmds_sent, updates_sent, sums_checked);
    $display("%0d weight writes saturated", sat_writes);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // result side: checking and back-pressure
  initial begin
    logic [SUM_W-1:0] exp_sum;
    int               hold_left;
    int               stall_left;
    bit               held;
    logic             rdy;
    hold_left  = 0;
    stall_left = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (sum_queue.size() == 0) begin
          $display("%0t: unexpected beat, got value_sum %h", $time, out_tdata[SUM_W-1:0]);
          fail_count++;
        end else begin
          exp_sum = sum_queue.pop_front();
          sums_checked++;
          if (out_tdata[SUM_W-1:0] !== exp_sum) begin
            $display("%0t: value_sum mismatch, expected %h, got %h",
                     $time, exp_sum, out_tdata[SUM_W-1:0]);
            fail_count++;
          end
        end
      end
      rdy = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!held && sums_checked >= 150) begin
        // long hold so the core fills and stops taking commands
        held      = 1'b1;
        hold_left = 500;
        rdy       = 1'b0;
      end else if (sums_checked >= 400 && sums_checked < 550) begin
        rdy = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
        rdy        = 1'b0;
      end
      out_tready <= rdy;
    end
  end

  // run limit, covering the weight clear after reset
  initial begin
    #150_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
design/nteu_pkg.sv
design/nteu_ram.sv
design/nteu_seq.sv
design/nteu_dp.sv
design/ntuple_value_evaluate_update_core.sv
dv/ntuple_value_evaluate_update_core_test.sv
